[rtl/assert_macros.svh]
// Assertion macros for the checker file of the queue block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle implication failed.");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle implication failed.");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("Next-cycle implication across reset failed.");

`endif

[rtl/fqr_pkg.sv]
// Types and constants of the queue with remove by value.
package fqr_pkg;

   localparam int DATA_W   = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int REQ_W    = ((MODE_W + DATA_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ = 2'd0,
      MODE_DEQ = 2'd1,
      MODE_REM = 2'd2,
      MODE_NOP = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_ENQ,
      OP_DEQ,
      OP_START,
      OP_SEARCH,
      OP_CLOSE
   } cell_op_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_SEARCH
   } fsm_type;

   typedef struct packed {
      cell_op_type       op;
      logic [DATA_W-1:0] key;
   } cell_cmd_type;

   typedef struct packed {
      logic              tok;
      logic              fnd;
      logic [DATA_W-1:0] value;
   } cell_link_type;

endpackage

[rtl/fqr_cell.sv]
// One storage cell of the queue chain, with its share of the search token.
module fqr_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fqr_pkg::cell_cmd_type cmd,
   input  logic [CNT_W-1:0]      count,
   input  fqr_pkg::cell_link_type upper,
   output fqr_pkg::cell_link_type lower
);

   logic [fqr_pkg::DATA_W-1:0] value_ff, value_in;
   logic                       tok_ff, tok_in;
   logic                       fnd_ff, fnd_in;
   logic                       mark_ff, mark_in;
   logic                       pass;
   logic                       match;

   assign pass  = tok_ff && !fnd_ff;
   assign match = pass && (value_ff == cmd.key);

   assign lower.tok   = tok_ff;
   assign lower.fnd   = fnd_ff || match;
   assign lower.value = value_ff;

   always_comb begin
      value_in = value_ff;
      tok_in   = tok_ff;
      fnd_in   = fnd_ff;
      mark_in  = mark_ff;
      unique case (cmd.op)
         fqr_pkg::OP_ENQ: begin
            if (count == CNT_W'(INDEX)) begin
               value_in = cmd.key;
            end
         end
         fqr_pkg::OP_DEQ: begin
            value_in = upper.value;
         end
         fqr_pkg::OP_START: begin
            tok_in  = (count == CNT_W'(INDEX + 1));
            fnd_in  = 1'b0;
            mark_in = 1'b0;
         end
         fqr_pkg::OP_SEARCH: begin
            tok_in  = upper.tok;
            fnd_in  = upper.fnd;
            mark_in = mark_ff || pass;
         end
         fqr_pkg::OP_CLOSE: begin
            if (mark_ff || pass) begin
               value_in = upper.value;
            end
         end
         fqr_pkg::OP_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         tok_ff  <= 1'b0;
         fnd_ff  <= 1'b0;
         mark_ff <= 1'b0;
      end else begin
         tok_ff  <= tok_in;
         fnd_ff  <= fnd_in;
         mark_ff <= mark_in;
      end
   end

endmodule

[rtl/fqr_rsp_buf.sv]
// Two-entry output register with skid stage for the result channel.
module fqr_rsp_buf #(
   parameter int WIDTH = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             room,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] main_ff, main_in;
   logic [WIDTH-1:0] skid_ff, skid_in;
   logic             main_v_ff, main_v_in;
   logic             skid_v_ff, skid_v_in;

   assign room      = !skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_in   = main_ff;
      skid_in   = skid_ff;
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      if (!main_v_ff || out_ready) begin
         main_in   = skid_v_ff ? skid_ff : push_data;
         main_v_in = skid_v_ff || push;
         skid_v_in = 1'b0;
      end else if (push) begin
         skid_in   = push_data;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

endmodule

[rtl/fifo_queue_with_remove_core.sv]
// Bounded queue of 32-bit values with dequeue of the oldest and remove of the newest match.
//
// The request channel (req_) carries one operation per beat: enqueue a value, dequeue the
// oldest value, remove the newest stored entry equal to a value, or do nothing. Every
// request beat yields exactly one response beat (rsp_) with a status, the dequeued value
// and the occupancy after the operation.
// Storage is a row of DEPTH cells; dequeue and removal shift the newer entries down by one.
// Enqueue, dequeue and the no-operation code are handled in the idle state: a beat can be
// accepted in every cycle while the response side has room, and its response is registered
// in the cycle after acceptance. A removal walks a token from the newest cell down to the
// oldest, one cell per cycle; an empty queue answers a miss and starts no walk. No request
// is accepted during the walk.
// The response side has an output register and a skid stage, so a request is still taken
// while one response waits; when both are full, req_tready drops until rsp_tready returns.
// Reset empties the queue and drops any pending responses; no clearing pass is needed.
module fifo_queue_with_remove_core #(
   parameter int  DEPTH = 16,
   localparam int OCC_W = $clog2(DEPTH + 1),
   localparam int RSP_W = ((fqr_pkg::STATUS_W + fqr_pkg::DATA_W + OCC_W + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [fqr_pkg::REQ_W-1:0] req_tdata,  // mode[1:0], data_in[33:2], zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata   // status, data_out, occupancy, zero pad
);

   localparam int DATA_LO = fqr_pkg::STATUS_W;
   localparam int OCC_LO  = fqr_pkg::STATUS_W + fqr_pkg::DATA_W;

   fqr_pkg::fsm_type       state_ff, state_in;
   logic [OCC_W-1:0]       count_ff, count_in;
   logic [fqr_pkg::DATA_W-1:0] key_ff, key_in;
   fqr_pkg::cell_cmd_type  cmd;
   fqr_pkg::cell_link_type lower_w [DEPTH];
   fqr_pkg::cell_link_type upper_w [DEPTH];
   fqr_pkg::mode_type      req_mode;
   logic [fqr_pkg::DATA_W-1:0] req_value;
   fqr_pkg::status_type    rsp_status;
   logic [fqr_pkg::DATA_W-1:0] rsp_value;
   logic [RSP_W-1:0]       push_data;
   logic                   push;
   logic                   room;
   logic                   accept;

   assign req_mode   = fqr_pkg::mode_type'(req_tdata[fqr_pkg::MODE_W-1:0]);
   assign req_value  = req_tdata[fqr_pkg::MODE_W +: fqr_pkg::DATA_W];
   assign req_tready = (state_ff == fqr_pkg::FSM_IDLE) && room;
   assign accept     = req_tvalid && req_tready;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_top
         assign upper_w[i] = '{tok: 1'b0, fnd: 1'b0, value: lower_w[i].value};
      end else begin : g_mid
         assign upper_w[i] = lower_w[i+1];
      end
      fqr_cell #(
         .INDEX (i),
         .CNT_W (OCC_W)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .count (count_ff),
         .upper (upper_w[i]),
         .lower (lower_w[i])
      );
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      cmd.op     = fqr_pkg::OP_HOLD;
      cmd.key    = (state_ff == fqr_pkg::FSM_SEARCH) ? key_ff : req_value;
      push       = 1'b0;
      rsp_status = fqr_pkg::ST_OK;
      rsp_value  = '0;
      unique case (state_ff)
         fqr_pkg::FSM_IDLE: begin
            if (accept) begin
               push = 1'b1;
               unique case (req_mode)
                  fqr_pkg::MODE_ENQ: begin
                     if (count_ff == OCC_W'(DEPTH)) begin
                        rsp_status = fqr_pkg::ST_FULL;
                     end else begin
                        cmd.op   = fqr_pkg::OP_ENQ;
                        count_in = count_ff + OCC_W'(1);
                     end
                  end
                  fqr_pkg::MODE_DEQ: begin
                     if (count_ff == '0) begin
                        rsp_status = fqr_pkg::ST_MISS;
                     end else begin
                        cmd.op    = fqr_pkg::OP_DEQ;
                        rsp_value = lower_w[0].value;
                        count_in  = count_ff - OCC_W'(1);
                     end
                  end
                  fqr_pkg::MODE_REM: begin
                     if (count_ff == '0) begin
                        rsp_status = fqr_pkg::ST_MISS;
                     end else begin
                        cmd.op   = fqr_pkg::OP_START;
                        key_in   = req_value;
                        push     = 1'b0;
                        state_in = fqr_pkg::FSM_SEARCH;
                     end
                  end
                  fqr_pkg::MODE_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         fqr_pkg::FSM_SEARCH: begin
            if (lower_w[0].tok) begin
               if (room) begin
                  push     = 1'b1;
                  state_in = fqr_pkg::FSM_IDLE;
                  if (lower_w[0].fnd) begin
                     cmd.op   = fqr_pkg::OP_CLOSE;
                     count_in = count_ff - OCC_W'(1);
                  end else begin
                     rsp_status = fqr_pkg::ST_MISS;
                  end
               end
            end else begin
               cmd.op = fqr_pkg::OP_SEARCH;
            end
         end
         default: begin
            state_in = fqr_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      push_data = '0;
      push_data[fqr_pkg::STATUS_W-1:0]      = rsp_status;
      push_data[DATA_LO +: fqr_pkg::DATA_W] = rsp_value;
      push_data[OCC_LO +: OCC_W]            = count_in;
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         state_ff <= fqr_pkg::FSM_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   fqr_rsp_buf #(
      .WIDTH (RSP_W)
   ) u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

[rtl/fqr_checker.sv]
// Port-level checker for the queue block, bound to its top level.
`include "assert_macros.svh"

module fqr_checker #(
   parameter int  DEPTH = 16,
   localparam int OCC_W = $clog2(DEPTH + 1),
   localparam int RSP_W = ((fqr_pkg::STATUS_W + fqr_pkg::DATA_W + OCC_W + 7) / 8) * 8
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [fqr_pkg::REQ_W-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_W-1:0]          rsp_tdata
);

   localparam int DATA_LO = fqr_pkg::STATUS_W;
   localparam int OCC_LO  = fqr_pkg::STATUS_W + fqr_pkg::DATA_W;

   logic [fqr_pkg::STATUS_W-1:0] rsp_status;
   logic [fqr_pkg::DATA_W-1:0]   rsp_value;
   logic [OCC_W-1:0]             rsp_occ;
   logic                         rsp_stall;
   logic                         rsp_full;
   logic                         rsp_not_ok;
   logic                         short_beat;

   assign rsp_status = rsp_tdata[fqr_pkg::STATUS_W-1:0];
   assign rsp_value  = rsp_tdata[DATA_LO +: fqr_pkg::DATA_W];
   assign rsp_occ    = rsp_tdata[OCC_LO +: OCC_W];
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_full   = rsp_tvalid && (rsp_status == fqr_pkg::ST_FULL);
   assign rsp_not_ok = rsp_tvalid && (rsp_status != fqr_pkg::ST_OK);
   assign short_beat = req_tvalid && req_tready &&
                       (req_tdata[fqr_pkg::MODE_W-1:0] != fqr_pkg::MODE_REM);

   `ASSERT_NEXT(rsp_stall_holds, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPLY(full_only_at_depth, clock, reset, rsp_full, rsp_occ == OCC_W'(DEPTH))
   `ASSERT_IMPLY(value_zero_unless_ok, clock, reset, rsp_not_ok, rsp_value == '0)
   `ASSERT_NEXT(short_beat_answers, clock, reset, short_beat, rsp_tvalid)
   `ASSERT_NEXT_ALWAYS(reset_drops_response, clock, reset, !rsp_tvalid)

endmodule

bind fifo_queue_with_remove_core fqr_checker #(
   .DEPTH (DEPTH)
) u_fqr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sv/fifo_queue_with_remove_core_tb.sv]
// Testbench of the queue core: a stimulus table, random traffic and a queue predictor.
module fifo_queue_with_remove_core_tb;

   localparam int DEPTH        = 16;
   localparam int OCC_W        = $clog2(DEPTH + 1);
   localparam int RSP_W        =
      ((fqr_pkg::STATUS_W + fqr_pkg::DATA_W + OCC_W + 7) / 8) * 8;
   localparam int RAND_ITEMS   = 620;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = DEPTH + 4;
   localparam int SHOW_LIMIT   = 10;

   typedef struct packed {
      fqr_pkg::status_type        status;
      logic [fqr_pkg::DATA_W-1:0] value;
      logic [OCC_W-1:0]           occ;
   } rsp_beat_type;

   typedef struct {
      fqr_pkg::mode_type          mode;
      logic [fqr_pkg::DATA_W-1:0] value;
      int                         reps;
      bit                         typed;
      rsp_beat_type               rsp;
   } plan_row_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic [fqr_pkg::REQ_W-1:0]   req_tdata  = '0;  // mode, data_in, zero pad
   logic                        rsp_tready = 1'b0;
   logic                        req_tready;
   logic                        rsp_tvalid;
   logic [RSP_W-1:0]            rsp_tdata;        // status, data_out, occupancy, zero pad

   logic [fqr_pkg::DATA_W-1:0]  held_values[$];
   rsp_beat_type                expected_rsp[$];
   int                          snd_idle_pct   = 26;
   int                          rcv_idle_pct   = 69;
   logic                        hold_go        = 1'b0;
   int                          hold_count     = 0;
   int                          fail_count     = 0;
   int                          mismatch_count = 0;
   int                          quiet_cycles   = 0;

   fifo_queue_with_remove_core #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_beat_type queue_step(input fqr_pkg::mode_type m,
                                               input logic [fqr_pkg::DATA_W-1:0] v);
      rsp_beat_type r;
      int           idx;
      r.status = fqr_pkg::ST_OK;
      r.value  = '0;
      case (m)
         fqr_pkg::MODE_ENQ: begin
            if (held_values.size() >= DEPTH) r.status = fqr_pkg::ST_FULL;
            else held_values.push_back(v);
         end
         fqr_pkg::MODE_DEQ: begin
            if (held_values.size() == 0) r.status = fqr_pkg::ST_MISS;
            else r.value = held_values.pop_front();
         end
         fqr_pkg::MODE_REM: begin
            idx = held_values.size() - 1;
            while (idx >= 0 && held_values[idx] != v) idx--;
            if (idx >= 0) held_values.delete(idx);
            else r.status = fqr_pkg::ST_MISS;
         end
         default: ;
      endcase
      r.occ = OCC_W'(held_values.size());
      return r;
   endfunction

   task automatic issue(input fqr_pkg::mode_type m, input logic [fqr_pkg::DATA_W-1:0] v,
                        input bit typed, input rsp_beat_type typed_rsp);
      rsp_beat_type predicted;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(fqr_pkg::REQ_W - fqr_pkg::MODE_W - fqr_pkg::DATA_W){1'b0}}, v, m};
      do @(posedge clock); while (!req_tready);
      predicted = queue_step(m, v);
      expected_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   always @(posedge clock) begin
      if (hold_go && hold_count < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = fqr_pkg::status_type'(rsp_tdata[fqr_pkg::STATUS_W-1:0]);
         got.value  = rsp_tdata[fqr_pkg::STATUS_W +: fqr_pkg::DATA_W];
         got.occ    = rsp_tdata[fqr_pkg::STATUS_W + fqr_pkg::DATA_W +: OCC_W];
         if (expected_rsp.size() == 0) begin
            fail_count++;
            if (mismatch_count < SHOW_LIMIT)
               $display("Response beat with no request outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.value !== want.value ||
                got.occ !== want.occ) begin
               fail_count++;
               if (mismatch_count < SHOW_LIMIT)
                  $display("Mismatch: expected status %0d data %h occ %0d, got %0d %h %0d",
                           want.status, want.value, want.occ,
                           got.status, got.value, got.occ);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      plan_row_type               plan[$];
      plan_row_type               row;
      fqr_pkg::mode_type          m;
      logic [fqr_pkg::DATA_W-1:0] v;
      int                         pick;
      int                         bias;
      int                         enq_cut;
      int                         deq_cut;

      plan.push_back('{fqr_pkg::MODE_DEQ, 32'h0000_0000, 1, 1'b1,
                       '{fqr_pkg::ST_MISS, 32'h0, 5'd0}});
      plan.push_back('{fqr_pkg::MODE_REM, 32'h0000_0000, 1, 1'b1,
                       '{fqr_pkg::ST_MISS, 32'h0, 5'd0}});
      plan.push_back('{fqr_pkg::MODE_NOP, 32'hFFFF_FFFF, 1, 1'b1,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd0}});
      plan.push_back('{fqr_pkg::MODE_ENQ, 32'h8000_0000, 1, 1'b1,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd1}});
      plan.push_back('{fqr_pkg::MODE_REM, 32'h8000_0000, 1, 1'b1,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd0}});
      plan.push_back('{fqr_pkg::MODE_ENQ, 32'h7FFF_FFFF, 1, 1'b1,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd1}});
      plan.push_back('{fqr_pkg::MODE_ENQ, 32'h8000_0000, 1, 1'b1,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd2}});
      plan.push_back('{fqr_pkg::MODE_ENQ, 32'h7FFF_FFFF, 1, 1'b1,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd3}});
      plan.push_back('{fqr_pkg::MODE_ENQ, 32'h0000_0000, 1, 1'b1,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd4}});
      plan.push_back('{fqr_pkg::MODE_ENQ, 32'hFFFF_FFFF, 1, 1'b1,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd5}});
      plan.push_back('{fqr_pkg::MODE_REM, 32'h7FFF_FFFF, 1, 1'b0,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd0}});
      plan.push_back('{fqr_pkg::MODE_REM, 32'h0001_2345, 1, 1'b1,
                       '{fqr_pkg::ST_MISS, 32'h0, 5'd4}});
      plan.push_back('{fqr_pkg::MODE_DEQ, 32'h0000_0000, 1, 1'b1,
                       '{fqr_pkg::ST_OK, 32'h7FFF_FFFF, 5'd3}});
      plan.push_back('{fqr_pkg::MODE_ENQ, 32'hA5A5_0000, 13, 1'b0,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd0}});
      plan.push_back('{fqr_pkg::MODE_ENQ, 32'h1234_5678, 1, 1'b1,
                       '{fqr_pkg::ST_FULL, 32'h0, 5'd16}});
      plan.push_back('{fqr_pkg::MODE_REM, 32'h8000_0000, 1, 1'b0,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd0}});
      plan.push_back('{fqr_pkg::MODE_DEQ, 32'h0000_0000, 1, 1'b0,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd0}});
      plan.push_back('{fqr_pkg::MODE_NOP, 32'h5555_AAAA, 1, 1'b0,
                       '{fqr_pkg::ST_OK, 32'h0, 5'd0}});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         for (int k = 0; k < row.reps; k++)
            issue(row.mode, row.value + k, row.typed, row.rsp);
      end

      bias = 0;
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i == RAND_ITEMS / 3) begin
            snd_idle_pct = 69;
            rcv_idle_pct <= 26;
         end
         if (i == 2 * RAND_ITEMS / 3) begin
            snd_idle_pct = 0;
            rcv_idle_pct <= 0;
            hold_go      <= 1'b1;
         end
         if (i % 30 == 0) bias = $urandom_range(2);
         enq_cut = (bias == 0) ? 60 : (bias == 1) ? 25 : 40;
         deq_cut = (bias == 0) ? 75 : (bias == 1) ? 60 : 65;
         pick = $urandom_range(99);
         v    = $urandom;
         if (pick < enq_cut) begin
            m = fqr_pkg::MODE_ENQ;
            case ($urandom_range(9))
               0, 1, 2: v = 32'h5A00_0000 | $urandom_range(7);
               3: begin
                  case ($urandom_range(3))
                     0: v = 32'h8000_0000;
                     1: v = 32'h7FFF_FFFF;
                     2: v = 32'h0000_0000;
                     default: v = 32'hFFFF_FFFF;
                  endcase
               end
               4: if (held_values.size() != 0)
                     v = held_values[$urandom_range(held_values.size() - 1)];
               default: ;
            endcase
         end else if (pick < deq_cut) begin
            m = fqr_pkg::MODE_DEQ;
         end else if (pick < 95) begin
            m = fqr_pkg::MODE_REM;
            if (held_values.size() != 0 && $urandom_range(3) != 0)
               v = held_values[$urandom_range(held_values.size() - 1)];
            else if ($urandom_range(1) == 1)
               v = 32'h5A00_0000 | $urandom_range(7);
         end else begin
            m = fqr_pkg::MODE_NOP;
         end
         issue(m, v, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
